@@ rtl/ccsd_pkg.sv @@
`default_nettype none

package ccsd_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int TIME_W        = 32;
    localparam int WINDOW_W      = 20;
    localparam int COUNT_W       = 8;
    localparam int BYTE_W        = 8;
    localparam int SLOT_W        = 3;
    localparam int DONE_W        = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = WINDOW_W;

    localparam logic [SAMPLE_W-1:0] RESET_THRESHOLD = SAMPLE_W'(200);
    localparam logic [WINDOW_W-1:0] RESET_WINDOW    = WINDOW_W'(9900);

    localparam int COUNT_OFFSET     = 5;
    localparam int COUNT_DIVISOR    = 3;
    localparam int SYMBOLS_PER_BYTE = 4;
    localparam int RECIP_MULT       = 171;
    localparam int RECIP_SHIFT      = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [SLOT_W-1:0]  SLOT_IDLE   = {SLOT_W{1'b1}};
    localparam logic [DONE_W-1:0]  LAST_SYMBOL = DONE_W'(SYMBOLS_PER_BYTE - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_SYMBOL_WINDOW = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_us;
    } sample_t;

    typedef struct packed {
        logic              byte_ready;
        logic [BYTE_W-1:0] received_byte;
        logic [BYTE_W-1:0] partial_byte;
    } result_t;

    // (count - 5) / 3 truncated toward zero, low two bits
    function automatic logic [1:0] symbol_bits(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0]   diff;
        logic [COUNT_W+8:0]   prod;
        diff = '0;
        prod = '0;
        if (count < COUNT_W'(COUNT_OFFSET))
        begin
            if (count < COUNT_W'(COUNT_OFFSET - COUNT_DIVISOR + 1))
            begin
                symbol_bits = 2'b11;
            end
            else
            begin
                symbol_bits = 2'b00;
            end
        end
        else
        begin
            diff = count - COUNT_W'(COUNT_OFFSET);
            prod = (COUNT_W+9)'(diff) * (COUNT_W+9)'(RECIP_MULT);
            symbol_bits = prod[RECIP_SHIFT+1:RECIP_SHIFT];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/ccsd_stream_if.sv @@
`default_nettype none

interface ccsd_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/ccsd_core.sv @@
`default_nettype none

module ccsd_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [ccsd_pkg::SAMPLE_W-1:0] threshold,
    input  wire logic [ccsd_pkg::WINDOW_W-1:0] symbol_window_us,
    input  wire ccsd_pkg::sample_t             item,
    output ccsd_pkg::result_t                  result
);

    import ccsd_pkg::*;

    logic [SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic                armed_reg, armed_next;
    logic                in_symbol_reg, in_symbol_next;
    logic [TIME_W-1:0]   symbol_start_reg, symbol_start_next;
    logic [SLOT_W-1:0]   slot_index_reg, slot_index_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [DONE_W-1:0]   done_reg, done_next;

    logic                above;
    logic                below;
    logic                rise;
    logic                close;
    logic                counting;
    logic [TIME_W-1:0]   elapsed;
    logic [1:0]          bits;
    logic [BYTE_W-1:0]   placed;

    always_comb
    begin
        above    = item.sample > threshold;
        below    = item.sample < threshold;
        rise     = above && (prev_sample_reg < threshold) && !armed_reg;

        armed_next        = armed_reg | rise;
        in_symbol_next    = in_symbol_reg;
        symbol_start_next = symbol_start_reg;
        slot_index_next   = slot_index_reg;
        count_next        = count_reg;
        byte_next         = byte_reg;
        done_next         = done_reg;
        result            = '0;

        // symbol start on the first crossing
        if (rise && !in_symbol_reg)
        begin
            symbol_start_next = item.now_us;
            slot_index_next   = slot_index_reg + SLOT_W'(1);
        end

        // symbol close
        elapsed = item.now_us - symbol_start_next;
        close   = below && in_symbol_reg && (elapsed > TIME_W'(symbol_window_us));
        bits    = symbol_bits(count_reg);
        placed  = BYTE_W'(bits) << {slot_index_next[1:0], 1'b0};
        if (close)
        begin
            if (!slot_index_next[SLOT_W-1])
            begin
                byte_next = byte_reg | placed;
            end
            if (done_reg == LAST_SYMBOL)
            begin
                result.byte_ready    = 1'b1;
                result.received_byte = byte_next;
                byte_next            = '0;
                done_next            = '0;
                slot_index_next      = SLOT_IDLE;
            end
            else
            begin
                done_next = done_reg + DONE_W'(1);
            end
            in_symbol_next = 1'b0;
            count_next     = '0;
        end

        // count the crossing
        counting = above && armed_next;
        if (counting)
        begin
            if (count_next != COUNT_MAX)
            begin
                count_next = count_next + COUNT_W'(1);
            end
            in_symbol_next = 1'b1;
            armed_next     = 1'b0;
        end

        prev_sample_next    = item.sample;
        result.partial_byte = byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg  <= '0;
            armed_reg        <= 1'b0;
            in_symbol_reg    <= 1'b0;
            symbol_start_reg <= '0;
            slot_index_reg   <= SLOT_IDLE;
            count_reg        <= '0;
            byte_reg         <= '0;
            done_reg         <= '0;
        end
        else if (step)
        begin
            prev_sample_reg  <= prev_sample_next;
            armed_reg        <= armed_next;
            in_symbol_reg    <= in_symbol_next;
            symbol_start_reg <= symbol_start_next;
            slot_index_reg   <= slot_index_next;
            count_reg        <= count_next;
            byte_reg         <= byte_next;
            done_reg         <= done_next;
        end
    end

`ifndef SYNTHESIS
    a_byte_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.byte_ready |=> done_reg == '0 && byte_reg == '0
            && slot_index_reg == SLOT_IDLE)
        else $error("state not cleared after byte completion");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        step && counting && count_reg == COUNT_MAX |=> count_reg == COUNT_MAX)
        else $error("crossing count wrapped");

    a_close_clears_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        step && close |=> !in_symbol_reg && count_reg == '0)
        else $error("symbol close left state behind");
`endif

endmodule

`default_nettype wire

@@ rtl/crossing_count_symbol_demodulator.sv @@
// channel   | dir  | payload                                      | handshake
// samples   | in   | sample[9:0], now_us[31:0]                    | valid/ready
// results   | out  | byte_ready, received_byte[7:0], partial_byte | valid/ready
// cfg       | in   | cfg_index[1:0], cfg_data[19:0]               | write enable
//
// one sample per cycle sustained while the result side is ready
// an input register feeds the symbol logic, whose output lands in a result register
// rst_n clears the handshake, the symbol state and loads the default registers
// a stalled result register holds the input register, which then drops ready
`default_nettype none

module crossing_count_symbol_demodulator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_enable,
    input  wire logic [ccsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ccsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    ccsd_stream_if.sink                           samples,
    ccsd_stream_if.source                         results
);

    import ccsd_pkg::*;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [WINDOW_W-1:0] window_reg;

    logic                in_valid_reg;
    sample_t             in_data_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;

    logic                advance;
    logic                in_take;
    result_t             core_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RESET_THRESHOLD;
            window_reg    <= RESET_WINDOW;
        end
        else if (cfg_write_enable)
        begin
            case (reg_index_t'(cfg_index))
                REG_THRESHOLD:     threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_SYMBOL_WINDOW: window_reg    <= cfg_data[WINDOW_W-1:0];
                default:           ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_take       = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= samples.data;
        end
    end

    ccsd_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .threshold        (threshold_reg),
        .symbol_window_us (window_reg),
        .item             (in_data_reg),
        .result           (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

`ifndef SYNTHESIS
    a_take_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted transaction not held in input register");

    a_process_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed transaction not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !advance)
        else $error("stalled result overwritten");

    a_ready_clears_partial: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.byte_ready |-> out_data_reg.partial_byte == '0)
        else $error("partial byte not cleared on completion");
`endif

endmodule

`default_nettype wire

@@ tb/crossing_count_symbol_demodulator_test.sv @@
`timescale 1ns / 1ps

module crossing_count_symbol_demodulator_test;

    import ccsd_pkg::*;

    localparam int RESULT_LATENCY   = 2;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RUN_LIMIT_NS     = 5_000_000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccsd_stream_if #(.payload_t(sample_t)) sample_bus ();
    ccsd_stream_if #(.payload_t(result_t)) result_bus ();

    crossing_count_symbol_demodulator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .samples          (sample_bus),
        .results          (result_bus)
    );

    always #5 clk = ~clk;

    // demodulator state as the predictor sees it
    logic [SAMPLE_W-1:0] level_threshold = RESET_THRESHOLD;
    logic [WINDOW_W-1:0] close_window    = RESET_WINDOW;
    logic [SAMPLE_W-1:0] last_level      = '0;
    logic                crossing_armed  = 1'b0;
    logic                symbol_open     = 1'b0;
    logic [TIME_W-1:0]   open_since_us   = '0;
    logic [SLOT_W-1:0]   slot_pos        = '1;
    logic [COUNT_W-1:0]  crossings       = '0;
    logic [BYTE_W-1:0]   byte_acc        = '0;
    int                  closed_symbols  = 0;

    result_t pending_results[$];
    result_t expected_now;

    logic [TIME_W-1:0] clock_us = '0;
    int crossing_step_max = 4;
    int samples_sent = 0;
    int results_checked = 0;
    int bytes_seen = 0;
    int mismatch_count = 0;
    bit sender_idling = 1'b1;
    bit receiver_idling = 1'b1;
    bit long_hold_request = 1'b0;

    function automatic result_t predict_demod_result(input logic [SAMPLE_W-1:0] level,
                                                     input logic [TIME_W-1:0] stamp);
        result_t outcome;
        int quotient;
        logic [TIME_W-1:0] elapsed;
        outcome = '0;
        if (level > level_threshold && last_level < level_threshold && !crossing_armed)
        begin
            crossing_armed = 1'b1;
            if (!symbol_open)
            begin
                open_since_us = stamp;
                slot_pos = slot_pos + 1'b1;
            end
        end
        elapsed = stamp - open_since_us;
        if (level < level_threshold && symbol_open && elapsed > TIME_W'(close_window))
        begin
            quotient = (int'(crossings) - COUNT_OFFSET) / COUNT_DIVISOR;
            if (slot_pos < SYMBOLS_PER_BYTE)
                byte_acc = byte_acc | (BYTE_W'(quotient[1:0]) << (2 * slot_pos));
            closed_symbols++;
            if (closed_symbols == SYMBOLS_PER_BYTE)
            begin
                outcome.byte_ready = 1'b1;
                outcome.received_byte = byte_acc;
                byte_acc = '0;
                closed_symbols = 0;
                slot_pos = '1;
            end
            symbol_open = 1'b0;
            crossings = '0;
        end
        if (level > level_threshold && crossing_armed)
        begin
            if (crossings != COUNT_MAX)
                crossings = crossings + 1'b1;
            symbol_open = 1'b1;
            crossing_armed = 1'b0;
        end
        last_level = level;
        outcome.partial_byte = byte_acc;
        return outcome;
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_below();
        if (level_threshold == '0)
            return '0;
        return SAMPLE_W'($urandom_range(0, level_threshold - 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_above();
        if (level_threshold == '1)
            return '1;
        return SAMPLE_W'($urandom_range(level_threshold + 1, 1023));
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = 0;
        if (sender_idling && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 13);
        repeat (gap)
        begin
            @(negedge clk);
            sample_bus.valid <= 1'b0;
        end
        @(negedge clk);
        sample_bus.valid <= 1'b1;
        sample_bus.data <= {level, stamp};
        do
            @(posedge clk);
        while (!sample_bus.ready);
        pending_results.push_back(predict_demod_result(level, stamp));
        samples_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_error($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        if (index == REG_THRESHOLD)
            level_threshold = value[SAMPLE_W-1:0];
        else if (index == REG_SYMBOL_WINDOW)
            close_window = value;
    endtask

    // rising crossings, then optionally a low sample past the window
    task automatic send_symbol(input int count, input bit close_it, input bit probe_window);
        repeat (count)
        begin
            send_sample(level_below(), clock_us);
            clock_us += $urandom_range(0, crossing_step_max);
            send_sample(level_above(), clock_us);
            clock_us += $urandom_range(0, crossing_step_max);
        end
        if (probe_window)
        begin
            clock_us = open_since_us + close_window;
            send_sample(level_below(), clock_us);
            clock_us += 1;
            send_sample(level_below(), clock_us);
        end
        else if (close_it)
        begin
            clock_us = open_since_us + close_window + 1 + $urandom_range(0, 3);
            send_sample(level_below(), clock_us);
        end
    endtask

    task automatic send_noise(input int count);
        int pick;
        logic [SAMPLE_W-1:0] level;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                level = level_threshold;
            else if (pick == 1)
                level = '0;
            else if (pick == 2)
                level = '1;
            else
                level = SAMPLE_W'($urandom);
            if ($urandom_range(0, 15) == 0)
                clock_us = $urandom;
            else
                clock_us += $urandom_range(0, 2 * close_window + 2);
            send_sample(level, clock_us);
        end
    endtask

    task automatic test_field_extremes();
        send_sample('0, '0);
        send_sample('1, '0);
        send_sample(level_threshold, 32'd100);
        send_sample(level_threshold + 1'b1, 32'd200);
        send_sample(level_threshold - 1'b1, '1);
        send_sample('1, '1);
        send_sample('0, RESET_WINDOW - 2);
        send_sample('0, RESET_WINDOW - 1);
        send_sample('0, RESET_WINDOW);
    endtask

    task automatic test_few_crossings();
        clock_us = 32'd50000;
        send_symbol(1, 1'b1, 1'b1);
        send_symbol(2, 1'b1, 1'b0);
        send_symbol(3, 1'b1, 1'b0);
        send_symbol(4, 1'b1, 1'b0);
    endtask

    task automatic test_time_wrap();
        clock_us = 32'hFFFF_FFF0;
        send_symbol(5, 1'b1, 1'b1);
    endtask

    task automatic test_register_extremes();
        drain_results();
        write_register(REG_THRESHOLD, {10'h3FF, 10'd0});
        send_noise(4);
        drain_results();
        write_register(REG_THRESHOLD, {10'($urandom), 10'h3FF});
        send_noise(4);
        drain_results();
        write_register(REG_THRESHOLD, {10'h2AA, 10'd512});
        write_register(REG_SYMBOL_WINDOW, '0);
        send_symbol(2, 1'b1, 1'b1);
        send_symbol(1, 1'b1, 1'b0);
        drain_results();
        write_register(REG_SYMBOL_WINDOW, '1);
        send_symbol(3, 1'b1, 1'b1);
        drain_results();
        write_register(REG_SPARE_2, '1);
        write_register(REG_SPARE_3, CFG_DATA_W'($urandom));
        send_symbol(2, 1'b1, 1'b0);
        send_symbol(6, 1'b1, 1'b0);
        drain_results();
        write_register(REG_SYMBOL_WINDOW, CFG_DATA_W'(40));
    endtask

    task automatic test_count_saturation();
        drain_results();
        write_register(REG_THRESHOLD, CFG_DATA_W'(300));
        write_register(REG_SYMBOL_WINDOW, '1);
        crossing_step_max = 1;
        send_symbol(270, 1'b1, 1'b0);
        drain_results();
        crossing_step_max = 4;
        write_register(REG_SYMBOL_WINDOW, CFG_DATA_W'(40));
    endtask

    task automatic test_backpressure();
        drain_results();
        sender_idling = 1'b0;
        long_hold_request = 1'b1;
        repeat (6) send_symbol(3, 1'b1, 1'b0);
        drain_results();
        sender_idling = 1'b1;
    endtask

    task automatic test_random_traffic(input int item_goal, input bit allow_idling);
        int pick;
        int phase_end;
        logic [SAMPLE_W-1:0] level;
        logic [WINDOW_W-1:0] win;
        item_goal += samples_sent;
        while (samples_sent < item_goal)
        begin
            drain_results();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                level = '0;
            else if (pick == 1)
                level = '1;
            else
                level = SAMPLE_W'($urandom_range(1, 1022));
            write_register(REG_THRESHOLD, {10'($urandom), level});
            pick = $urandom_range(0, 19);
            if (pick < 14)
                win = WINDOW_W'($urandom_range(0, 64));
            else if (pick < 18)
                win = WINDOW_W'($urandom_range(65, 5000));
            else if (pick == 18)
                win = '1;
            else
                win = WINDOW_W'($urandom);
            write_register(REG_SYMBOL_WINDOW, win);
            crossing_step_max = int'(win >> 5) + 1;
            sender_idling = allow_idling && ($urandom_range(0, 3) != 0);
            receiver_idling = allow_idling && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                clock_us = $urandom;
            phase_end = samples_sent + $urandom_range(60, 160);
            while (samples_sent < phase_end && samples_sent < item_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_symbol($urandom_range(1, 16), 1'b1, pick < 8);
                else if (pick < 85)
                    send_symbol($urandom_range(1, 6), 1'b0, 1'b0);
                else
                    send_noise($urandom_range(1, 8));
            end
        end
    endtask

    // result side: random stalls plus the long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (receiver_idling && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error("result arrived with no sample pending");
            end
            else
            begin
                expected_now = pending_results.pop_front();
                if (result_bus.data.byte_ready !== expected_now.byte_ready)
                    report_error($sformatf("transaction %0d byte_ready got %b want %b",
                        results_checked, result_bus.data.byte_ready,
                        expected_now.byte_ready));
                if (result_bus.data.received_byte !== expected_now.received_byte)
                    report_error($sformatf("transaction %0d received_byte got %h want %h",
                        results_checked, result_bus.data.received_byte,
                        expected_now.received_byte));
                if (result_bus.data.partial_byte !== expected_now.partial_byte)
                    report_error($sformatf("transaction %0d partial_byte got %h want %h",
                        results_checked, result_bus.data.partial_byte,
                        expected_now.partial_byte));
            end
            if (result_bus.data.byte_ready === 1'b1)
                bytes_seen++;
            results_checked++;
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("crossing_count_symbol_demodulator regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = '0;
        sample_bus.valid = 1'b0;
        sample_bus.data = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_few_crossings();
        test_time_wrap();
        test_register_extremes();
        test_count_saturation();
        test_backpressure();
        test_random_traffic(600, 1'b1);
        test_random_traffic(180, 1'b0);
        drain_results();
        repeat (4 * RESULT_LATENCY) @(posedge clk);

        $display("covered %0d samples, %0d results checked, %0d completed bytes",
            samples_sent, results_checked, bytes_seen);
        $display("thresholds 0..1023, windows 0..1048575, time wrap, count saturation, stalls");
        if (mismatch_count == 0)
            $display("crossing_count_symbol_demodulator regression: pass");
        else
            $display("crossing_count_symbol_demodulator regression: fail");
        $finish;
    end

endmodule
